// ===== sv/fpba_pkg.sv =====
`timescale 1ns / 1ps

package fpba_pkg;

	localparam int NUM_BLOCKS_DEF = 16;
	localparam int SIZE_BITS_DEF  = 16;

	localparam int IDX_W    = 4;
	localparam int SIZE_W   = 16;
	localparam int POLICY_W = 2;
	localparam int COUNT_W  = 5;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 5;

	localparam int QUEUE_DEPTH = 2;

	localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
	localparam logic [POLICY_W-1:0] POL_BEST  = 2'd1;
	localparam logic [POLICY_W-1:0] POL_WORST = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_POLICY      = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 4'd1;

	localparam logic MODE_LOAD    = 1'b0;
	localparam logic MODE_REQUEST = 1'b1;

	typedef struct packed {
		logic              mode;
		logic [IDX_W-1:0]  block_index;
		logic [SIZE_W-1:0] size;
	} fpba_cmd_t;

	typedef struct packed {
		logic             granted;
		logic [IDX_W-1:0] placed_block;
	} fpba_rsp_t;

	typedef struct packed {
		logic busy;
		logic finishing;
	} fpba_back_st_t;

endpackage

// ===== sv/fpba_front.sv =====
`timescale 1ns / 1ps

module fpba_front #(
	parameter int NUM_BLOCKS = fpba_pkg::NUM_BLOCKS_DEF
) (
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  fpba_pkg::fpba_cmd_t cmd,
	input  logic              q_full,
	output logic              q_push,
	output fpba_pkg::fpba_cmd_t q_word
);
	import fpba_pkg::*;

	logic in_range;
	logic keep;

	// loads past the table are dropped here, they never reach the back end
	assign in_range  = 32'(cmd.block_index) < 32'(NUM_BLOCKS);
	assign keep      = (cmd.mode == MODE_REQUEST) || in_range;
	assign cmd_ready = !q_full;
	assign q_push    = cmd_valid && !q_full && keep;
	assign q_word    = cmd;

endmodule

// ===== sv/fpba_queue.sv =====
`timescale 1ns / 1ps

module fpba_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  fpba_pkg::fpba_cmd_t push_word,
	output logic                full,
	output logic                head_valid,
	input  logic                pop,
	output fpba_pkg::fpba_cmd_t head_word
);
	import fpba_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	fpba_cmd_t       ent_q [QUEUE_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   cnt_q;
	logic            do_push;
	logic            do_pop;

	assign full       = cnt_q == CW'(QUEUE_DEPTH);
	assign head_valid = cnt_q != '0;
	assign head_word  = ent_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (32'(wr_ptr_q) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (32'(rd_ptr_q) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== sv/fpba_back.sv =====
`timescale 1ns / 1ps

module fpba_back #(
	parameter int NUM_BLOCKS = fpba_pkg::NUM_BLOCKS_DEF,
	parameter int SIZE_BITS  = fpba_pkg::SIZE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [fpba_pkg::POLICY_W-1:0] policy,
	input  logic [fpba_pkg::COUNT_W-1:0]  block_count,
	input  logic                          q_valid,
	input  fpba_pkg::fpba_cmd_t           q_word,
	output logic                          q_pop,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output fpba_pkg::fpba_rsp_t           rsp,
	output fpba_pkg::fpba_back_st_t       st
);
	import fpba_pkg::*;

	localparam int AW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
	localparam int CW = $clog2(NUM_BLOCKS + 1);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_FINISH = 2'd2;

	logic [SIZE_BITS-1:0] mem [NUM_BLOCKS];
	logic [SIZE_BITS-1:0] rdata_q;

	logic [1:0]           state_q;
	logic [CW-1:0]        iss_q;
	logic [CW-1:0]        cnt_q;
	logic                 rv_q;
	logic [AW-1:0]        ridx_q;
	logic [SIZE_BITS-1:0] req_q;
	logic                 found_q;
	logic [AW-1:0]        pick_q;
	logic [SIZE_BITS-1:0] best_q;
	logic                 rsp_valid_q;
	fpba_rsp_t            rsp_q;

	logic [31:0]          idx32;
	logic [31:0]          size32;
	logic [31:0]          cnt32;
	logic [31:0]          pick32;
	logic [AW-1:0]        load_addr;
	logic [SIZE_BITS-1:0] cmd_size;
	logic [CW-1:0]        cnt_sat;
	logic                 is_load;
	logic                 issuing;
	logic                 fits;
	logic                 take;
	logic                 slot_free;
	logic                 we;
	logic [AW-1:0]        waddr;
	logic [SIZE_BITS-1:0] wdata;

	assign idx32     = 32'(q_word.block_index);
	assign size32    = 32'(q_word.size);
	assign load_addr = idx32[AW-1:0];
	assign cmd_size  = size32[SIZE_BITS-1:0];
	assign cnt32     = (32'(block_count) > 32'(NUM_BLOCKS)) ? 32'(NUM_BLOCKS)
	                                                        : 32'(block_count);
	assign cnt_sat   = cnt32[CW-1:0];
	assign pick32    = 32'(pick_q);
	assign is_load   = q_word.mode == MODE_LOAD;

	assign q_pop     = q_valid && (state_q == ST_IDLE);
	assign issuing   = (state_q == ST_SCAN) && (iss_q < cnt_q);
	assign slot_free = !rsp_valid_q || rsp_ready;

	// first fit keeps the first hit; best and worst replace on a strict win
	assign fits = rdata_q >= req_q;
	always_comb begin
		take = 1'b0;
		if (rv_q && fits) begin
			if (!found_q) begin
				take = 1'b1;
			end else if (policy == POL_BEST) begin
				take = rdata_q < best_q;
			end else if (policy == POL_WORST) begin
				take = rdata_q > best_q;
			end
		end
	end

	always_comb begin
		we    = 1'b0;
		waddr = load_addr;
		wdata = cmd_size;
		if (q_pop && is_load) begin
			we = 1'b1;
		end else if ((state_q == ST_FINISH) && slot_free && found_q) begin
			we    = 1'b1;
			waddr = pick_q;
			wdata = best_q - req_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[iss_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (q_pop && !is_load) begin
			req_q <= cmd_size;
			cnt_q <= cnt_sat;
		end
		if (issuing) begin
			ridx_q <= iss_q[AW-1:0];
		end
		if (take) begin
			pick_q <= ridx_q;
			best_q <= rdata_q;
		end
		if ((state_q == ST_FINISH) && slot_free) begin
			rsp_q.granted      <= found_q;
			rsp_q.placed_block <= found_q ? pick32[IDX_W-1:0] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			iss_q       <= '0;
			rv_q        <= 1'b0;
			found_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_FINISH) && slot_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_pop && !is_load) begin
						iss_q   <= '0;
						rv_q    <= 1'b0;
						found_q <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					rv_q <= issuing;
					if (issuing) begin
						iss_q <= iss_q + 1'b1;
					end
					if (take) begin
						found_q <= 1'b1;
					end
					if (!issuing && !rv_q) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign rsp          = rsp_q;
	assign st.busy      = state_q != ST_IDLE;
	assign st.finishing = state_q == ST_FINISH;

endmodule

// ===== sv/fit_policy_block_allocator_top.sv =====
`timescale 1ns / 1ps
// load word: popped from the queue into the table write, one load per cycle when idle
// request word: the scan reads the free-size table once per cycle over n entries,
//   n = min(block_count, NUM_BLOCKS); the finish step waits for a free response slot
// one request in flight at a time; the next is not popped until the finish step ends;
//   a 2-entry queue decouples command intake
// reset clears policy, block count, queue and sequencer; the table is not cleared
module fit_policy_block_allocator_top #(
	parameter int NUM_BLOCKS = fpba_pkg::NUM_BLOCKS_DEF,
	parameter int SIZE_BITS  = fpba_pkg::SIZE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cmd_valid,
	output logic                            cmd_ready,
	input  fpba_pkg::fpba_cmd_t             cmd,
	output logic                            rsp_valid,
	input  logic                            rsp_ready,
	output fpba_pkg::fpba_rsp_t             rsp,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [fpba_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fpba_pkg::CFG_DATA_W-1:0] cfg_data
);
	import fpba_pkg::*;

	logic [POLICY_W-1:0] policy_q;
	logic [COUNT_W-1:0]  block_count_q;
	logic                q_full;
	logic                q_push;
	fpba_cmd_t           q_in;
	logic                q_valid;
	logic                q_pop;
	fpba_cmd_t           q_head;
	fpba_back_st_t       st;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q      <= POL_FIRST;
			block_count_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_POLICY:      policy_q      <= cfg_data[POLICY_W-1:0];
				REG_BLOCK_COUNT: block_count_q <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	fpba_front #(
		.NUM_BLOCKS(NUM_BLOCKS)
	) u_front (
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd      (cmd),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_word   (q_in)
	);

	fpba_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_word (q_in),
		.full      (q_full),
		.head_valid(q_valid),
		.pop       (q_pop),
		.head_word (q_head)
	);

	fpba_back #(
		.NUM_BLOCKS(NUM_BLOCKS),
		.SIZE_BITS (SIZE_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.policy     (policy_q),
		.block_count(block_count_q),
		.q_valid    (q_valid),
		.q_word     (q_head),
		.q_pop      (q_pop),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp),
		.st         (st)
	);

`ifndef SYNTHESIS
	// a response word only appears out of the finish step of a request
	a_rsp_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(st.finishing))
		else $error("response raised outside finish step");

	a_finish_is_busy: assert property (@(posedge clk) disable iff (!arst_n)
		st.finishing |-> st.busy && !q_pop)
		else $error("queue popped while finishing a request");

	a_reject_zero_index: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.granted |-> rsp.placed_block == '0)
		else $error("rejected request carries a block index");
`endif

endmodule

// ===== tb/sv/fpba_grant_checker.sv =====
`timescale 1ns / 1ps

module fpba_grant_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cmd_valid,
	input  logic                            cmd_ready,
	input  fpba_pkg::fpba_cmd_t             cmd,
	input  logic                            rsp_valid,
	input  logic                            rsp_ready,
	input  fpba_pkg::fpba_rsp_t             rsp,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [fpba_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fpba_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                              mismatch_count,
	output int                              awaiting
);
	import fpba_pkg::*;

	localparam int NUM_BLOCKS = NUM_BLOCKS_DEF;

	logic [SIZE_W-1:0]   free_tbl [NUM_BLOCKS];
	logic [POLICY_W-1:0] cur_policy;
	logic [COUNT_W-1:0]  cur_count;
	fpba_rsp_t           grant_queue [$];

	// scan the blocks in use, shrink the chosen one
	function automatic fpba_rsp_t place_request(input logic [SIZE_W-1:0] want);
		int                span;
		int                pick;
		bit                found;
		logic [SIZE_W-1:0] best;
		fpba_rsp_t         r;
		span = (cur_count > NUM_BLOCKS) ? NUM_BLOCKS : int'(cur_count);
		found = 1'b0;
		pick = 0;
		best = '0;
		for (int j = 0; j < span; j++) begin
			if (free_tbl[j] >= want) begin
				if (!found) begin
					found = 1'b1;
					pick = j;
					best = free_tbl[j];
					// first fit, and the unused code acts the same
					if (cur_policy != POL_BEST && cur_policy != POL_WORST)
						break;
				end else if (cur_policy == POL_BEST && free_tbl[j] < best) begin
					pick = j;
					best = free_tbl[j];
				end else if (cur_policy == POL_WORST && free_tbl[j] > best) begin
					pick = j;
					best = free_tbl[j];
				end
			end
		end
		r = '0;
		if (found) begin
			free_tbl[pick] = free_tbl[pick] - want;
			r.granted = 1'b1;
			r.placed_block = IDX_W'(pick);
		end
		return r;
	endfunction

	task automatic flag(input string what);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t: %s", $time, what);
	endtask

	always @(posedge clk or negedge arst_n) begin
		fpba_rsp_t want;
		if (!arst_n) begin
			cur_policy = POL_FIRST;
			cur_count = '0;
			grant_queue.delete();
			mismatch_count = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_POLICY: cur_policy = cfg_data[POLICY_W-1:0];
					REG_BLOCK_COUNT: cur_count = cfg_data[COUNT_W-1:0];
					default: ;
				endcase
			end
			if (rsp_valid && rsp_ready) begin
				if (grant_queue.size() == 0) begin
					flag($sformatf("word with nothing pending: granted %0d placed_block %0d",
						rsp.granted, rsp.placed_block));
				end else begin
					want = grant_queue.pop_front();
					if (rsp.granted !== want.granted)
						flag($sformatf("granted: expected %0d, got %0d",
							want.granted, rsp.granted));
					if (rsp.placed_block !== want.placed_block)
						flag($sformatf("placed_block: expected %0d, got %0d",
							want.placed_block, rsp.placed_block));
				end
			end
			if (cmd_valid && cmd_ready) begin
				if (cmd.mode == MODE_LOAD)
					free_tbl[cmd.block_index] = cmd.size;
				else
					grant_queue.push_back(place_request(cmd.size));
			end
		end
		awaiting = grant_queue.size();
	end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import fpba_pkg::*;

	localparam logic [POLICY_W-1:0] POL_SPARE = 2'd3;
	localparam int SETTLE_CYCLES = 2 * (NUM_BLOCKS_DEF + 4) + 8;
	localparam int HOLD_CYCLES   = 400;
	localparam int STALL_LIMIT   = 4000;
	localparam int PHASE_WORDS   = 152;
	localparam int NUM_PHASES    = 12;

	typedef struct packed {
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
	} reg_write_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cmd_valid = 1'b0;
	logic                  cmd_ready;
	fpba_cmd_t             cmd = '0;
	logic                  rsp_valid;
	logic                  rsp_ready = 1'b0;
	fpba_rsp_t             rsp;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int mismatch_count;
	int awaiting;
	int rsp_seen = 0;
	int idle_cycles = 0;
	int cmd_streak = 0;
	int rsp_streak = 0;
	int rsp_hold_at = 150;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	fit_policy_block_allocator_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	fpba_grant_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd_valid      (cmd_valid),
		.cmd_ready      (cmd_ready),
		.cmd            (cmd),
		.rsp_valid      (rsp_valid),
		.rsp_ready      (rsp_ready),
		.rsp            (rsp),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.mismatch_count (mismatch_count),
		.awaiting       (awaiting)
	);

	always @(posedge clk) begin
		if (rsp_valid && rsp_ready)
			rsp_seen++;
		if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
	end

	initial begin
		while (idle_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("fit_policy_block_allocator_top test failed");
		$finish;
	end

	// mostly short gaps, a few long ones, now and then a run with none
	task automatic pick_gap(inout int streak, output int gap);
		int r;
		r = $urandom_range(0, 99);
		if (streak > 0) begin
			streak--;
			gap = 0;
		end else if (r < 2) begin
			streak = $urandom_range(30, 120);
			gap = 0;
		end else if (r < 50) begin
			gap = 0;
		end else if (r < 85) begin
			gap = $urandom_range(1, 3);
		end else if (r < 96) begin
			gap = $urandom_range(4, 12);
		end else begin
			gap = $urandom_range(20, 60);
		end
	endtask

	function automatic fpba_cmd_t mk_word(input logic m, input int idx, input int sz);
		fpba_cmd_t w;
		w.mode = m;
		w.block_index = IDX_W'(idx);
		w.size = SIZE_W'(sz);
		return w;
	endfunction

	function automatic fpba_cmd_t random_word(input int req_pct);
		fpba_cmd_t w;
		int        r;
		r = $urandom_range(0, 99);
		w.block_index = IDX_W'($urandom_range(0, 15));
		if ($urandom_range(0, 99) < req_pct) begin
			w.mode = MODE_REQUEST;
			if (r < 40)
				w.size = SIZE_W'($urandom_range(0, 127));
			else if (r < 70)
				w.size = SIZE_W'($urandom_range(0, 1023));
			else if (r < 90)
				w.size = SIZE_W'($urandom);
			else
				w.size = r[0] ? '0 : '1;
		end else begin
			w.mode = MODE_LOAD;
			if (r < 45)
				w.size = SIZE_W'($urandom_range(0, 255));
			else if (r < 75)
				w.size = SIZE_W'($urandom_range(0, 4095));
			else
				w.size = SIZE_W'($urandom);
		end
		return w;
	endfunction

	// called at a falling edge; returns at a falling edge after the word is taken
	task automatic send_word(input fpba_cmd_t w);
		int gap;
		cmd_valid <= 1'b1;
		cmd <= w;
		do @(posedge clk); while (!cmd_ready);
		@(negedge clk);
		pick_gap(cmd_streak, gap);
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic program_regs(input logic [POLICY_W-1:0] pol, input logic [COUNT_W-1:0] cnt);
		reg_write_t writes [$];
		reg_write_t pw;
		reg_write_t cw;
		reg_write_t stray;
		pw.idx = REG_POLICY;
		pw.data = CFG_DATA_W'(pol);
		cw.idx = REG_BLOCK_COUNT;
		cw.data = cnt;
		if ($urandom_range(0, 1))
			writes = '{pw, cw};
		else
			writes = '{cw, pw};
		// unassigned indexes must leave the settings alone
		if ($urandom_range(0, 3) == 0) begin
			stray.idx = CFG_IDX_W'($urandom_range(REG_BLOCK_COUNT + 1, (1 << CFG_IDX_W) - 1));
			stray.data = CFG_DATA_W'($urandom);
			writes.push_front(stray);
		end
		foreach (writes[k]) begin
			cfg_valid <= 1'b1;
			cfg_index <= writes[k].idx;
			cfg_data <= writes[k].data;
			do @(posedge clk); while (!cfg_ready);
			@(negedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic settle();
		cmd_valid <= 1'b0;
		while (awaiting != 0)
			@(negedge clk);
		// loads leave no result, give the last ones time to reach the table
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin
		int                  run;
		int                  gap;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (rsp_seen >= rsp_hold_at) begin
				// long hold-off so the block backs up and stalls its input
				rsp_hold_at = rsp_seen + 450;
				rsp_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			rsp_ready <= 1'b1;
			if ($urandom_range(0, 15) == 0)
				run = $urandom_range(40, 150);
			else
				run = $urandom_range(1, 8);
			repeat (run) @(negedge clk);
			pick_gap(rsp_streak, gap);
			if (gap > 0) begin
				rsp_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
	end

	initial begin
		logic [SIZE_W-1:0]   seed_sizes [16];
		logic [POLICY_W-1:0] phase_pol [NUM_PHASES];
		logic [COUNT_W-1:0]  phase_cnt [NUM_PHASES];
		int                  req_pct;
		seed_sizes = '{16'd100, 16'hFFFF, 16'd50, 16'd50, 16'd200, 16'd30, 16'd0, 16'd200,
			16'h8000, 16'd10, 16'd1, 16'h7FFF, 16'd49, 16'hFFFE, 16'd3, 16'd0};
		phase_pol = '{POL_FIRST, POL_BEST, POL_WORST, POL_SPARE, POL_BEST, POL_WORST,
			POL_FIRST, POL_BEST, POL_WORST, POL_FIRST, POL_BEST, POL_WORST};
		phase_cnt = '{5'd16, 5'd16, 5'd16, 5'd16, 5'd1, 5'd31, 5'd0, 5'd0, 5'd17, 5'd0,
			5'd0, 5'd0};
		phase_cnt[7] = COUNT_W'($urandom_range(2, 15));
		phase_cnt[9] = COUNT_W'($urandom_range(0, 31));
		phase_cnt[10] = COUNT_W'($urandom_range(0, 31));
		phase_cnt[11] = COUNT_W'($urandom_range(0, 31));

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// block count still zero: nothing granted, loads land above the count anyway
		send_word(mk_word(MODE_REQUEST, 0, 5));
		foreach (seed_sizes[b])
			send_word(mk_word(MODE_LOAD, b, seed_sizes[b]));

		settle();
		program_regs(POL_FIRST, 5'd16);
		send_word(mk_word(MODE_REQUEST, 7, 0));
		send_word(mk_word(MODE_REQUEST, 15, 16'hFFFF));
		send_word(mk_word(MODE_REQUEST, 0, 16'hFFFF));
		send_word(mk_word(MODE_REQUEST, 3, 50));

		// ties between equal sizes go to the lower index
		settle();
		program_regs(POL_BEST, 5'd16);
		send_word(mk_word(MODE_REQUEST, 9, 50));

		settle();
		program_regs(POL_WORST, 5'd16);
		send_word(mk_word(MODE_REQUEST, 1, 1));

		settle();
		program_regs(POL_SPARE, 5'd16);
		send_word(mk_word(MODE_REQUEST, 12, 40));

		// count above the table size saturates
		settle();
		program_regs(POL_WORST, 5'd31);
		send_word(mk_word(MODE_REQUEST, 4, 1000));

		for (int p = 0; p < NUM_PHASES; p++) begin
			settle();
			program_regs(phase_pol[p], phase_cnt[p]);
			req_pct = $urandom_range(25, 55);
			repeat (PHASE_WORDS)
				send_word(random_word(req_pct));
		end

		settle();
		if (mismatch_count == 0)
			$display("fit_policy_block_allocator_top test passed");
		else
			$display("fit_policy_block_allocator_top test failed");
		$finish;
	end

endmodule
